@@ hw/rtl/ntmd_pkg.sv @@
// Shared types and constants of the nibble tile map decoder.
`timescale 1ns / 1ps
`default_nettype none

package ntmd_pkg;

  localparam int ByteW = 8;
  localparam int NibW  = 4;
  localparam int TileW = 7;
  localparam int PosW  = 7;
  localparam int CntW  = 3;

  // Decoder state kept between input words.
  typedef struct packed {
    logic            pv;
    logic [NibW-1:0] pn;
    logic [PosW-1:0] td;
  } st_t;

  // Tiles produced by one nibble: one value, single or repeated, or an ascending pair.
  typedef struct packed {
    logic [CntW-1:0]  cnt;
    logic [TileW-1:0] base;
    logic             pair;
    logic             pv;
    logic [NibW-1:0]  pn;
  } grp_t;

  // Emission plan for one accepted input word.
  typedef struct packed {
    logic [TileW-1:0] base1;
    logic             pair1;
    logic [CntW-1:0]  n1;
    logic [TileW-1:0] base2;
    logic             pair2;
    logic [CntW-1:0]  total;
    logic [PosW-1:0]  pos;
  } plan_t;

endpackage

`default_nettype wire

@@ hw/rtl/ntmd_if.sv @@
// Valid/ready channel interfaces for input words and tile results.
`timescale 1ns / 1ps
`default_nettype none

interface ntmd_in_if;
  import ntmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] code_byte;
  logic             start_map;

  modport source (output valid, output code_byte, output start_map, input ready);
  modport sink   (input valid, input code_byte, input start_map, output ready);
endinterface

interface ntmd_out_if;
  import ntmd_pkg::*;
  logic             valid;
  logic             ready;
  logic [TileW-1:0] tile_code;
  logic [PosW-1:0]  tile_position;
  logic             last_of_byte;
  logic             last_of_map;

  modport source (output valid, output tile_code, output tile_position,
                  output last_of_byte, output last_of_map, input ready);
  modport sink   (input valid, input tile_code, input tile_position,
                  input last_of_byte, input last_of_map, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ntmd_decode.sv @@
// Decodes both nibbles of one input word into an emission plan and the next state.
`timescale 1ns / 1ps
`default_nettype none

module ntmd_decode #(
  parameter int MAP_TILES = 80
) (
  input  logic [ntmd_pkg::ByteW-1:0] code_byte,
  input  logic                       start_map,
  input  ntmd_pkg::st_t              st,
  output ntmd_pkg::plan_t            plan,
  output ntmd_pkg::st_t              st_nxt
);
  import ntmd_pkg::*;

  localparam logic [PosW:0] MapW = (PosW+1)'(MAP_TILES);

  function automatic grp_t nib_decode(input logic pv, input logic [NibW-1:0] pn,
                                      input logic [NibW-1:0] nib);
    grp_t            g;
    logic [TileW-1:0] v;
    v = {1'b0, pn[1:0], nib};
    g = '0;
    if (pv) begin
      g.pv = 1'b0;
      g.pn = '0;
      if (!pn[2]) begin
        g.cnt  = CntW'(1);
        g.base = v;
      end else begin
        g.cnt  = CntW'(4);
        g.base = v + TileW'(2);
      end
    end else if (!nib[3]) begin
      g.pv = 1'b0;
      g.pn = '0;
      if (nib < NibW'(5)) begin
        g.cnt  = CntW'(1);
        g.base = {3'b000, nib} + TileW'(2);
      end else begin
        g.cnt  = CntW'(2);
        g.base = {2'b00, nib, 1'b0};
        g.pair = 1'b1;
      end
    end else begin
      g.pv = 1'b1;
      g.pn = nib;
    end
    return g;
  endfunction

  logic [PosW-1:0] td0, td1, td2;
  logic            pv0, pv1;
  logic [NibW-1:0] pn0, pn1;
  logic            full0, full1;
  logic [PosW:0]   room0, room1;
  logic [CntW-1:0] n1, n2;
  grp_t            g1, g2;

  always_comb begin
    td0   = start_map ? '0 : st.td;
    pv0   = start_map ? 1'b0 : st.pv;
    pn0   = start_map ? '0 : st.pn;
    full0 = {1'b0, td0} >= MapW;
    room0 = MapW - {1'b0, td0};
    g1    = nib_decode(pv0, pn0, code_byte[ByteW-1:NibW]);
    if (full0) begin
      n1 = '0;
    end else if ({{(PosW+1-CntW){1'b0}}, g1.cnt} > room0) begin
      n1 = room0[CntW-1:0];
    end else begin
      n1 = g1.cnt;
    end
    td1 = td0 + {{(PosW-CntW){1'b0}}, n1};
    pv1 = full0 ? pv0 : g1.pv;
    pn1 = full0 ? pn0 : g1.pn;

    full1 = {1'b0, td1} >= MapW;
    room1 = MapW - {1'b0, td1};
    g2    = nib_decode(pv1, pn1, code_byte[NibW-1:0]);
    if (full1) begin
      n2 = '0;
    end else if ({{(PosW+1-CntW){1'b0}}, g2.cnt} > room1) begin
      n2 = room1[CntW-1:0];
    end else begin
      n2 = g2.cnt;
    end
    td2 = td1 + {{(PosW-CntW){1'b0}}, n2};

    st_nxt.td = td2;
    st_nxt.pv = full1 ? pv1 : g2.pv;
    st_nxt.pn = full1 ? pn1 : g2.pn;

    plan.base1 = g1.base;
    plan.pair1 = g1.pair;
    plan.n1    = n1;
    plan.base2 = g2.base;
    plan.pair2 = g2.pair;
    plan.total = CntW'({1'b0, n1} + {1'b0, n2});
    plan.pos   = td0;
  end

endmodule

`default_nettype wire

@@ hw/rtl/nibble_tile_map_decoder.sv @@
// Top level of the nibble tile map decoder: word intake, tile sequencer and output register.
//
//   channel  | dir | payload                                              | handshake
//   in_chan  | in  | code_byte[7:0], start_map                            | valid/ready
//   out_chan | out | tile_code[6:0], tile_position[6:0], last_of_byte,   | valid/ready
//            |     | last_of_map                                          |
//
// An input word is decoded in the cycle it is accepted and yields zero to six tiles.
// The sequencer sends one tile per cycle into the output register while the output is not
// stalled; the next word is taken in the cycle the last tile moves out.
// Synchronous active-low reset clears the map position, the pending nibble and all valids.
// A stall on the output holds the register and the sequencer; input then waits.
`timescale 1ns / 1ps
`default_nettype none

module nibble_tile_map_decoder #(
  parameter int MAP_TILES = 80
) (
  input  logic         clk,
  input  logic         rst_n,
  ntmd_in_if.sink      in_chan,
  ntmd_out_if.source   out_chan
);
  import ntmd_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(MAP_TILES - 1);

  st_t              st_r, st_nxt;
  plan_t            plan_r, plan_nxt;
  logic             plan_valid_r;
  logic [CntW-1:0]  idx_r;
  logic             out_valid_r;
  logic [TileW-1:0] out_code_r;
  logic [PosW-1:0]  out_pos_r;
  logic             out_lob_r;
  logic             out_lom_r;

  logic             adv;
  logic             last_tile;
  logic             in_acc;
  logic [CntW-1:0]  j;
  logic [TileW-1:0] tile_val;
  logic [PosW-1:0]  tile_pos;

  ntmd_decode #(.MAP_TILES(MAP_TILES)) u_decode (
    .code_byte (in_chan.code_byte),
    .start_map (in_chan.start_map),
    .st        (st_r),
    .plan      (plan_nxt),
    .st_nxt    (st_nxt)
  );

  assign adv       = plan_valid_r && (!out_valid_r || out_chan.ready);
  assign last_tile = idx_r == (plan_r.total - CntW'(1));
  assign in_chan.ready = !plan_valid_r || (adv && last_tile);
  assign in_acc    = in_chan.valid && in_chan.ready;

  always_comb begin
    j = idx_r - plan_r.n1;
    if (idx_r < plan_r.n1) begin
      tile_val = plan_r.base1 + (plan_r.pair1 ? {{(TileW-CntW){1'b0}}, idx_r} : '0);
    end else begin
      tile_val = plan_r.base2 + (plan_r.pair2 ? {{(TileW-CntW){1'b0}}, j} : '0);
    end
    tile_pos = plan_r.pos + {{(PosW-CntW){1'b0}}, idx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      plan_valid_r <= 1'b0;
      idx_r        <= '0;
    end else if (in_acc) begin
      st_r         <= st_nxt;
      plan_r       <= plan_nxt;
      plan_valid_r <= plan_nxt.total != '0;
      idx_r        <= '0;
    end else if (adv) begin
      if (last_tile) begin
        plan_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
      out_code_r  <= tile_val;
      out_pos_r   <= tile_pos;
      out_lob_r   <= last_tile;
      out_lom_r   <= tile_pos == LastPos;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.tile_code     = out_code_r;
  assign out_chan.tile_position = out_pos_r;
  assign out_chan.last_of_byte  = out_lob_r;
  assign out_chan.last_of_map   = out_lom_r;

  a_idx_in_plan: assert property (@(posedge clk) disable iff (!rst_n)
    plan_valid_r |-> idx_r < plan_r.total)
    else $error("Tile index ran past the plan of the current word.");

  a_pos_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> {1'b0, out_pos_r} < (PosW+1)'(MAP_TILES))
    else $error("Tile position lies outside the map.");

  a_accept_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && plan_valid_r) |-> (adv && last_tile))
    else $error("A word was taken while the previous word still had tiles to send.");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, st_r.td} <= (PosW+1)'(MAP_TILES))
    else $error("Fill count exceeds the map size.");

endmodule

`default_nettype wire
